// File: sv/bounded_stack_unique_key_top_defines.svh
`ifndef BOUNDED_STACK_UNIQUE_KEY_TOP_DEFINES_SVH
`define BOUNDED_STACK_UNIQUE_KEY_TOP_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define BSUK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted
`define BSUK_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/bsuk_pkg.sv
`timescale 1ns / 1ps

package bsuk_pkg;

	localparam int MAX_DEPTH = 128;
	localparam int IDX_W     = $clog2(MAX_DEPTH);
	localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
	localparam int CAP_W     = 8;
	localparam int LIM_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int KEY_W     = 32;
	localparam int PAY_W     = 32;
	localparam int ENTRY_W   = KEY_W + PAY_W;
	localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_DUP   = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_TOP  = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

endpackage

// File: sv/bsuk_req_if.sv
`timescale 1ns / 1ps

interface bsuk_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [31:0] entry_key;
	logic [31:0]        entry_payload;

	modport source (output valid, output command, output entry_key, output entry_payload,
		input ready);
	modport sink (input valid, input command, input entry_key, input entry_payload,
		output ready);
endinterface

// File: sv/bsuk_rsp_if.sv
`timescale 1ns / 1ps

interface bsuk_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] out_key;
	logic [31:0]        out_payload;
	logic [7:0]         depth_now;
	logic [31:0]        pushes_total;

	modport source (output valid, output status, output out_key, output out_payload,
		output depth_now, output pushes_total, input ready);
	modport sink (input valid, input status, input out_key, input out_payload,
		input depth_now, input pushes_total, output ready);
endinterface

// File: sv/bsuk_ram.sv
`timescale 1ns / 1ps

module bsuk_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/bounded_stack_unique_key_top.sv
`timescale 1ns / 1ps

// Bounded LIFO stack of (key, payload) entries with unique keys.
// req channel: valid/ready with command (push, pop, peek, clear), entry_key and
// entry_payload. rsp channel: valid/ready with status, out_key, out_payload,
// depth_now and pushes_total; exactly one response per request.
// cfg_we/cfg_wdata write capacity_limit (reset value 100); write only when idle.
// Entries live in one 64-bit single-write, single-read RAM with registered read.
// A push walks every stored key through one shared comparator, one entry per cycle,
// and stops early on a duplicate; on an empty stack or when full it skips the scan.
// Pop and peek read the top entry from RAM in ST_TOP; clear goes straight to ST_RESP.
// req.ready is high only while the sequencer is idle; one request is in work at a time.
// The response register decouples the sides: a new request is taken while the last
// response still waits; a finished request holds in the sequencer while rsp stalls.
// arst_n clears the stack depth, push count, sequencer and rsp.valid and restores
// capacity_limit; RAM contents are not cleared (only entries below depth are read).
module bounded_stack_unique_key_top
	import bsuk_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	bsuk_req_if.sink       req,
	bsuk_rsp_if.source     rsp,
	input  logic           cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	state_t              state_q;
	cmd_t                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [PAY_W-1:0]    pay_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CNT_W-1:0]    depth_q;
	logic [31:0]         pushes_q;
	logic [CNT_W-1:0]    scan_idx_q;
	logic                pend_s1;
	logic                last_s1;
	status_t             status_q;
	logic [KEY_W-1:0]    res_key_q;
	logic [PAY_W-1:0]    res_pay_q;

	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic [KEY_W-1:0]    rsp_key_q;
	logic [PAY_W-1:0]    rsp_pay_q;
	logic [7:0]          rsp_depth_q;
	logic [31:0]         rsp_pushes_q;

	logic                req_fire;
	cmd_t                req_cmd;
	logic [LIM_W-1:0]    limit;
	logic                is_full;
	logic                is_empty;
	logic                issue;
	logic                match;
	logic                out_free;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign req_cmd   = cmd_t'(req.command);

	// effective limit is min(capacity_limit, MAX_DEPTH)
	assign limit    = (LIM_W'(cap_q) > LIM_W'(MAX_DEPTH)) ? LIM_W'(MAX_DEPTH) : LIM_W'(cap_q);
	assign is_full  = LIM_W'(depth_q) >= limit;
	assign is_empty = (depth_q == '0);

	assign issue    = (state_q == ST_SCAN) && (scan_idx_q < depth_q);
	assign match    = (ram_rdata[ENTRY_W-1:PAY_W] == key_q);
	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = scan_idx_q[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = depth_q[IDX_W-1:0];
		ram_wdata = {key_q, pay_q};
		if (state_q == ST_IDLE) begin
			ram_wdata = {req.entry_key, req.entry_payload};
			if (req_fire && req_cmd == CMD_PUSH && !is_full && is_empty) begin
				ram_we = 1'b1;
			end
			if (req_fire && (req_cmd == CMD_POP || req_cmd == CMD_PEEK) && !is_empty) begin
				ram_re    = 1'b1;
				ram_raddr = IDX_W'(depth_q - CNT_W'(1));
			end
		end else if (state_q == ST_SCAN) begin
			ram_re = issue;
			if (pend_s1 && last_s1 && !match) begin
				ram_we = 1'b1;
			end
		end
	end

	bsuk_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// compare stage of the key scan acts in the cycle after the RAM read is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
			last_s1 <= (scan_idx_q == CNT_W'(depth_q - CNT_W'(1)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= CMD_PUSH;
			key_q      <= '0;
			pay_q      <= '0;
			depth_q    <= '0;
			pushes_q   <= '0;
			scan_idx_q <= '0;
			status_q   <= STAT_OK;
			res_key_q  <= '0;
			res_pay_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						cmd_q      <= req_cmd;
						key_q      <= req.entry_key;
						pay_q      <= req.entry_payload;
						status_q   <= STAT_OK;
						res_key_q  <= '0;
						res_pay_q  <= '0;
						scan_idx_q <= '0;
						unique case (req_cmd)
							CMD_PUSH: begin
								if (is_full) begin
									status_q <= STAT_FULL;
									state_q  <= ST_RESP;
								end else if (is_empty) begin
									depth_q  <= depth_q + CNT_W'(1);
									pushes_q <= pushes_q + 32'd1;
									state_q  <= ST_RESP;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							CMD_POP, CMD_PEEK: begin
								if (is_empty) begin
									status_q <= STAT_EMPTY;
									state_q  <= ST_RESP;
								end else begin
									state_q <= ST_TOP;
								end
							end
							CMD_CLEAR: begin
								depth_q <= '0;
								state_q <= ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (pend_s1 && match) begin
						status_q <= STAT_DUP;
						state_q  <= ST_RESP;
					end else if (pend_s1 && last_s1) begin
						depth_q  <= depth_q + CNT_W'(1);
						pushes_q <= pushes_q + 32'd1;
						state_q  <= ST_RESP;
					end
				end
				ST_TOP: begin
					res_key_q <= ram_rdata[ENTRY_W-1:PAY_W];
					res_pay_q <= ram_rdata[PAY_W-1:0];
					if (cmd_q == CMD_POP) begin
						depth_q <= depth_q - CNT_W'(1);
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					// hold until the response register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= STAT_OK;
			rsp_key_q    <= '0;
			rsp_pay_q    <= '0;
			rsp_depth_q  <= '0;
			rsp_pushes_q <= '0;
		end else if (state_q == ST_RESP && out_free) begin
			rsp_valid_q  <= 1'b1;
			rsp_status_q <= status_q;
			rsp_key_q    <= res_key_q;
			rsp_pay_q    <= res_pay_q;
			rsp_depth_q  <= 8'(depth_q);
			rsp_pushes_q <= pushes_q;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.out_key      = rsp_key_q;
	assign rsp.out_payload  = rsp_pay_q;
	assign rsp.depth_now    = rsp_depth_q;
	assign rsp.pushes_total = rsp_pushes_q;

endmodule

// File: sv/bsuk_checker.sv
`timescale 1ns / 1ps
`include "bounded_stack_unique_key_top_defines.svh"

module bsuk_checker
	import bsuk_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic [31:0] out_key,
	input logic [31:0] out_payload,
	input logic [7:0]  depth_now,
	input logic [31:0] pushes_total
);

	`BSUK_ASSERT_ALWAYS(a_no_rsp_in_reset, (!arst_n |-> !rsp_valid), "rsp valid during reset")

	`BSUK_ASSERT(a_busy_after_req, (req_valid && req_ready |=> !req_ready), "req taken while busy")

	`BSUK_ASSERT(a_refused_zero, (rsp_valid && status != STAT_OK |-> out_key == '0 && out_payload == '0), "refused request returned an entry")

	`BSUK_ASSERT(a_depth_bound, (rsp_valid |-> int'(depth_now) <= MAX_DEPTH), "depth beyond storage")

	`BSUK_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(pushes_total)), "stalled rsp changed")

endmodule

bind bounded_stack_unique_key_top bsuk_checker u_bsuk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.out_key      (rsp.out_key),
	.out_payload  (rsp.out_payload),
	.depth_now    (rsp.depth_now),
	.pushes_total (rsp.pushes_total)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bsuk_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_OFF    = 400;
	localparam int NPROBE      = 25;
	localparam int NPHASE      = 6;

	// capacity per random phase, -1 picks one at run time
	localparam int PH_CAP   [NPHASE] = '{128, 255, 2, 1, 100, -1};
	localparam int PH_ITEMS [NPHASE] = '{220, 60, 70, 40, 150, 60};
	localparam int PH_PUSH  [NPHASE] = '{90, 30, 50, 50, 70, 60};
	localparam int PH_CLEAR [NPHASE] = '{0, 0, 5, 5, 3, 5};

	typedef struct packed {
		status_t     status;
		logic [31:0] key;
		logic [31:0] payload;
		logic [7:0]  depth;
		logic [31:0] pushes;
	} stack_rsp_t;

	typedef struct packed {
		logic        is_cfg;
		logic [7:0]  cap;
		cmd_t        cmd;
		logic [31:0] key;
		logic [31:0] payload;
		logic        typed;
		stack_rsp_t  want;
	} probe_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;

	bsuk_req_if req_ch ();
	bsuk_rsp_if rsp_ch ();

	bounded_stack_unique_key_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow copy of the stack
	logic [31:0] held_key [MAX_DEPTH];
	logic [31:0] held_pay [MAX_DEPTH];
	int          held_depth = 0;
	logic [31:0] push_count = '0;
	logic [7:0]  cap_now = CAP_RESET;

	stack_rsp_t  pending [$];
	int          faults = 0;
	int          delivered = 0;
	int          cycles = 0;
	int          burst_left = 0;

	probe_t probes [NPROBE] = '{
		'{1'b0, 8'd0, CMD_POP, '0, '0, 1'b1, '{STAT_EMPTY, '0, '0, 8'd0, 32'd0}},
		'{1'b0, 8'd0, CMD_PEEK, '0, '0, 1'b1, '{STAT_EMPTY, '0, '0, 8'd0, 32'd0}},
		'{1'b0, 8'd0, CMD_CLEAR, '0, '0, 1'b1, '{STAT_OK, '0, '0, 8'd0, 32'd0}},
		'{1'b0, 8'd0, CMD_PUSH, 32'h8000_0000, 32'h0000_0000, 1'b1,
			'{STAT_OK, '0, '0, 8'd1, 32'd1}},
		'{1'b0, 8'd0, CMD_PUSH, 32'h7fff_ffff, 32'hffff_ffff, 1'b1,
			'{STAT_OK, '0, '0, 8'd2, 32'd2}},
		'{1'b0, 8'd0, CMD_PUSH, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{STAT_OK, '0, '0, 8'd3, 32'd3}},
		'{1'b0, 8'd0, CMD_PUSH, 32'hffff_ffff, 32'ha5a5_a5a5, 1'b1,
			'{STAT_OK, '0, '0, 8'd4, 32'd4}},
		'{1'b0, 8'd0, CMD_PUSH, 32'h8000_0000, 32'h0000_0001, 1'b1,
			'{STAT_DUP, '0, '0, 8'd4, 32'd4}},
		'{1'b0, 8'd0, CMD_PEEK, '0, '0, 1'b1,
			'{STAT_OK, 32'hffff_ffff, 32'ha5a5_a5a5, 8'd4, 32'd4}},
		'{1'b0, 8'd0, CMD_POP, '0, '0, 1'b1,
			'{STAT_OK, 32'hffff_ffff, 32'ha5a5_a5a5, 8'd3, 32'd4}},
		'{1'b0, 8'd0, CMD_POP, '0, '0, 1'b1, '{STAT_OK, '0, '0, 8'd2, 32'd4}},
		'{1'b0, 8'd0, CMD_PUSH, 32'h7fff_ffff, 32'h5a5a_5a5a, 1'b1,
			'{STAT_DUP, '0, '0, 8'd2, 32'd4}},
		'{1'b0, 8'd0, CMD_CLEAR, '0, '0, 1'b1, '{STAT_OK, '0, '0, 8'd0, 32'd4}},
		'{1'b0, 8'd0, CMD_PUSH, 32'h7fff_ffff, 32'h0000_ffff, 1'b1,
			'{STAT_OK, '0, '0, 8'd1, 32'd5}},
		'{1'b1, 8'd1, CMD_PUSH, '0, '0, 1'b0, '{STAT_OK, '0, '0, '0, '0}},
		'{1'b0, 8'd0, CMD_PUSH, 32'h0000_0001, 32'h0000_0001, 1'b1,
			'{STAT_FULL, '0, '0, 8'd1, 32'd5}},
		// full and duplicate at once: full wins
		'{1'b0, 8'd0, CMD_PUSH, 32'h7fff_ffff, 32'h0000_0002, 1'b1,
			'{STAT_FULL, '0, '0, 8'd1, 32'd5}},
		'{1'b0, 8'd0, CMD_PEEK, '0, '0, 1'b1,
			'{STAT_OK, 32'h7fff_ffff, 32'h0000_ffff, 8'd1, 32'd5}},
		'{1'b1, 8'd0, CMD_PUSH, '0, '0, 1'b0, '{STAT_OK, '0, '0, '0, '0}},
		'{1'b0, 8'd0, CMD_CLEAR, '0, '0, 1'b1, '{STAT_OK, '0, '0, 8'd0, 32'd5}},
		'{1'b0, 8'd0, CMD_PUSH, 32'h0000_0002, 32'h0000_0002, 1'b1,
			'{STAT_FULL, '0, '0, 8'd0, 32'd5}},
		'{1'b1, 8'd255, CMD_PUSH, '0, '0, 1'b0, '{STAT_OK, '0, '0, '0, '0}},
		'{1'b0, 8'd0, CMD_PUSH, 32'h0000_0003, 32'h0000_0003, 1'b0,
			'{STAT_OK, '0, '0, '0, '0}},
		'{1'b0, 8'd0, CMD_POP, '0, '0, 1'b0, '{STAT_OK, '0, '0, '0, '0}},
		'{1'b0, 8'd0, CMD_POP, '0, '0, 1'b0, '{STAT_OK, '0, '0, '0, '0}}
	};

	function automatic stack_rsp_t stack_predict(input cmd_t c, input logic [31:0] k,
			input logic [31:0] p);
		stack_rsp_t r;
		int lim;
		bit seen;
		r = '{STAT_OK, '0, '0, '0, '0};
		lim = (cap_now > MAX_DEPTH) ? MAX_DEPTH : cap_now;
		seen = 1'b0;
		case (c)
			CMD_PUSH: begin
				for (int i = 0; i < held_depth; i++)
					if (held_key[i] == k)
						seen = 1'b1;
				if (held_depth >= lim)
					r.status = STAT_FULL;
				else if (seen)
					r.status = STAT_DUP;
				else begin
					held_key[held_depth] = k;
					held_pay[held_depth] = p;
					held_depth++;
					push_count++;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (held_depth == 0)
					r.status = STAT_EMPTY;
				else begin
					r.key = held_key[held_depth-1];
					r.payload = held_pay[held_depth-1];
					if (c == CMD_POP)
						held_depth--;
				end
			end
			default: begin
				held_depth = 0;
			end
		endcase
		r.depth = held_depth[7:0];
		r.pushes = push_count;
		return r;
	endfunction

	task automatic offer(input cmd_t c, input logic [31:0] k, input logic [31:0] p,
			input bit typed, input stack_rsp_t want);
		stack_rsp_t got;
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= c;
		req_ch.entry_key <= k;
		req_ch.entry_payload <= p;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		burst_left--;
		got = stack_predict(c, k, p);
		pending.push_back(typed ? want : got);
	endtask

	// write only once every request has been answered
	task automatic set_capacity(input logic [7:0] v);
		req_ch.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_now = v;
		burst_left = 0;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		int roll;
		int pick;
		cmd_t c;
		logic [31:0] k;
		logic [31:0] p;
		stack_rsp_t none;
		none = '{STAT_OK, '0, '0, '0, '0};
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_PUSH;
		req_ch.entry_key <= '0;
		req_ch.entry_payload <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < NPROBE; n++) begin
			if (probes[n].is_cfg)
				set_capacity(probes[n].cap);
			else
				offer(probes[n].cmd, probes[n].key, probes[n].payload, probes[n].typed,
					probes[n].want);
		end

		for (int ph = 0; ph < NPHASE; ph++) begin
			set_capacity((PH_CAP[ph] < 0) ? 8'($urandom_range(1, 128)) : 8'(PH_CAP[ph]));
			for (int n = 0; n < PH_ITEMS[ph]; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < PH_PUSH[ph])
					c = CMD_PUSH;
				else if (roll < PH_PUSH[ph] + PH_CLEAR[ph])
					c = CMD_CLEAR;
				else
					c = ($urandom_range(0, 4) < 3) ? CMD_POP : CMD_PEEK;
				// mostly fresh keys, some reused ones to hit the duplicate scan
				pick = $urandom_range(0, 99);
				if (pick < 70 || (pick < 80 && held_depth == 0))
					k = $urandom;
				else if (pick < 80)
					k = held_key[$urandom_range(0, held_depth - 1)];
				else if (pick < 90)
					k = $urandom_range(0, 15);
				else begin
					case ($urandom_range(0, 3))
						0: k = 32'h8000_0000;
						1: k = 32'h7fff_ffff;
						2: k = 32'hffff_ffff;
						default: k = 32'h0000_0000;
					endcase
				end
				if ($urandom_range(0, 9) == 0)
					p = $urandom_range(0, 1) ? '1 : '0;
				else
					p = $urandom;
				offer(c, k, p, 1'b0, none);
			end
		end

		req_ch.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
		if (faults == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// response side: alternating runs, a free stretch now and then, one long hold-off
	initial begin
		int run_left;
		int run_no;
		bit level;
		bit held_off;
		run_left = 0;
		run_no = 0;
		level = 1'b0;
		held_off = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && delivered >= 40) begin
				held_off = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
				run_left = 0;
			end
			if (run_left == 0) begin
				run_no++;
				level = !level;
				if (run_no % 10 == 0) begin
					level = 1'b1;
					run_left = 80;
				end else
					run_left = level ? $urandom_range(1, 12) : $urandom_range(1, 6);
			end
			rsp_ch.ready <= level;
			run_left--;
		end
	end

	always @(posedge clk) begin
		stack_rsp_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			delivered++;
			if (pending.size() == 0) begin
				$error("response with no request outstanding");
				faults++;
			end else begin
				exp_r = pending.pop_front();
				if (rsp_ch.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
					faults++;
				end
				if (rsp_ch.out_key !== exp_r.key) begin
					$error("out_key: expected %h, got %h", exp_r.key, rsp_ch.out_key);
					faults++;
				end
				if (rsp_ch.out_payload !== exp_r.payload) begin
					$error("out_payload: expected %h, got %h", exp_r.payload,
						rsp_ch.out_payload);
					faults++;
				end
				if (rsp_ch.depth_now !== exp_r.depth) begin
					$error("depth_now: expected %0d, got %0d", exp_r.depth, rsp_ch.depth_now);
					faults++;
				end
				if (rsp_ch.pushes_total !== exp_r.pushes) begin
					$error("pushes_total: expected %0d, got %0d", exp_r.pushes,
						rsp_ch.pushes_total);
					faults++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
